// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Expression must hold at every clock edge outside reset.
`define CLPC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion violated");
// Antecedent implies consequent in the same cycle.
`define CLPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion violated");
`else
`define CLPC_ASSERT(lbl, expr)
`define CLPC_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// ----- rtl/clpc_pkg.sv -----
package clpc_pkg;

  // Pixel coordinate width of the input channel.
  localparam int PIXEL_COORD_BITS = 12;

  // Register field widths.
  localparam int CW_COORD = 18;
  localparam int CW_THICK = 12;
  localparam int CW_ALPHA = 8;
  localparam int CFG_IDX_W = 3;

  // Difference width: holds pixel centre minus an endpoint and endpoint deltas.
  localparam int DW = (PIXEL_COORD_BITS + 6 > 19) ? PIXEL_COORD_BITS + 6 : 19;
  // Sum-of-products width (signed).
  localparam int SW = 2 * DW + 1;
  // Magnitude of the cross product, and its half width.
  localparam int CW = 2 * DW;
  localparam int HW = DW;
  // Width of the root search working values.
  localparam int NW = 4 * DW + 8;
  // Bits of the distance result (1/128 pixel units).
  localparam int KW = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_END_X   = 3'd2,
    CFG_END_Y   = 3'd3,
    CFG_THICK   = 3'd4,
    CFG_ALPHA   = 3'd5
  } cfg_idx_t;

  // Segment endpoints as seen by the geometry pipeline.
  typedef struct packed {
    logic signed [CW_COORD-1:0] ax;
    logic signed [CW_COORD-1:0] ay;
    logic signed [CW_COORD-1:0] bx;
    logic signed [CW_COORD-1:0] by;
  } seg_t;

  // Root search operands: largest k with k*k*den <= num.
  typedef struct packed {
    logic          valid;
    logic [NW-1:0] num;
    logic [NW-1:0] den;
  } root_req_t;

endpackage

// ----- rtl/clpc_geom.sv -----
module clpc_geom (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   adv,
  input  logic                                   load,
  input  logic [clpc_pkg::PIXEL_COORD_BITS-1:0]  px,
  input  logic [clpc_pkg::PIXEL_COORD_BITS-1:0]  py,
  input  clpc_pkg::seg_t                         seg,
  output clpc_pkg::root_req_t                    req
);
  import clpc_pkg::*;

  localparam int PAD = DW - PIXEL_COORD_BITS - 4;

  // Stage 1: offsets of the pixel centre from both endpoints, segment delta.
  logic                 v1_r;
  logic signed [DW-1:0] dax_r, day_r, dbx_r, dby_r, abx_r, aby_r;
  logic signed [DW-1:0] cx, cy, ax, ay, bx, by;

  assign cx = $signed({{PAD{1'b0}}, px, 4'b1000});
  assign cy = $signed({{PAD{1'b0}}, py, 4'b1000});
  assign ax = {{(DW-CW_COORD){seg.ax[CW_COORD-1]}}, seg.ax};
  assign ay = {{(DW-CW_COORD){seg.ay[CW_COORD-1]}}, seg.ay};
  assign bx = {{(DW-CW_COORD){seg.bx[CW_COORD-1]}}, seg.bx};
  assign by = {{(DW-CW_COORD){seg.by[CW_COORD-1]}}, seg.by};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dax_r <= cx - ax;
      day_r <= cy - ay;
      dbx_r <= cx - bx;
      dby_r <= cy - by;
      abx_r <= bx - ax;
      aby_r <= by - ay;
    end
  end

  // Stage 2: all products of the offsets.
  logic                     v2_r;
  logic signed [2*DW-1:0]   paa_x_r, paa_y_r, pbb_x_r, pbb_y_r;
  logic signed [2*DW-1:0]   pdot_x_r, pdot_y_r, pcr_a_r, pcr_b_r, pll_x_r, pll_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      paa_x_r  <= dax_r * dax_r;
      paa_y_r  <= day_r * day_r;
      pbb_x_r  <= dbx_r * dbx_r;
      pbb_y_r  <= dby_r * dby_r;
      pdot_x_r <= dax_r * abx_r;
      pdot_y_r <= day_r * aby_r;
      pcr_a_r  <= dax_r * aby_r;
      pcr_b_r  <= day_r * abx_r;
      pll_x_r  <= abx_r * abx_r;
      pll_y_r  <= aby_r * aby_r;
    end
  end

  // Stage 3: sums, region decision and cross product magnitude.
  logic                 v3_r;
  logic                 int3_r;
  logic [CW-1:0]        c3_r;
  logic [SW-1:0]        dd3_r;
  logic [SW-1:0]        len3_r;
  logic signed [SW-1:0] len_s, dot_s, da_s, db_s, cr_s, cr_abs;
  logic                 near_start, past_end;

  always_comb begin
    len_s = {pll_x_r[2*DW-1], pll_x_r} + {pll_y_r[2*DW-1], pll_y_r};
    dot_s = {pdot_x_r[2*DW-1], pdot_x_r} + {pdot_y_r[2*DW-1], pdot_y_r};
    da_s  = {paa_x_r[2*DW-1], paa_x_r} + {paa_y_r[2*DW-1], paa_y_r};
    db_s  = {pbb_x_r[2*DW-1], pbb_x_r} + {pbb_y_r[2*DW-1], pbb_y_r};
    cr_s  = {pcr_a_r[2*DW-1], pcr_a_r} - {pcr_b_r[2*DW-1], pcr_b_r};
    cr_abs = cr_s[SW-1] ? -cr_s : cr_s;
    near_start = (len_s == '0) || (dot_s <= 0);
    past_end   = (dot_s >= len_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      int3_r <= !near_start && !past_end;
      c3_r   <= cr_abs[CW-1:0];
      dd3_r  <= near_start ? da_s : db_s;
      len3_r <= len_s;
    end
  end

  // Stage 4: square the cross product as three half-width partial products.
  logic            v4_r;
  logic            int4_r;
  logic [2*HW-1:0] hh4_r, hl4_r, ll4_r;
  logic [SW-1:0]   dd4_r;
  logic [SW-1:0]   len4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      int4_r <= int3_r;
      hh4_r  <= c3_r[CW-1:HW] * c3_r[CW-1:HW];
      hl4_r  <= c3_r[CW-1:HW] * c3_r[HW-1:0];
      ll4_r  <= c3_r[HW-1:0] * c3_r[HW-1:0];
      dd4_r  <= dd3_r;
      len4_r <= len3_r;
    end
  end

  // Stage 5: assemble the scaled squared distance numerator and denominator.
  logic          v5_r;
  logic [NW-1:0] num5_r, den5_r;
  logic [NW-1:0] csq, num_nxt, den_nxt;

  always_comb begin
    csq = ({{(NW-2*HW){1'b0}}, hh4_r} << (2*HW))
        + ({{(NW-2*HW){1'b0}}, hl4_r} << (HW+1))
        + {{(NW-2*HW){1'b0}}, ll4_r};
    if (int4_r) begin
      num_nxt = csq << 6;
      den_nxt = {{(NW-SW){1'b0}}, len4_r};
    end else begin
      num_nxt = {{(NW-SW){1'b0}}, dd4_r} << 6;
      den_nxt = NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num5_r <= num_nxt;
      den5_r <= den_nxt;
    end
  end

  assign req.valid = v5_r;
  assign req.num   = num5_r;
  assign req.den   = den5_r;

endmodule

// ----- rtl/clpc_root.sv -----
module clpc_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  clpc_pkg::root_req_t           req,
  output logic                          dist_valid,
  output logic [clpc_pkg::KW-1:0]       dist_k
);
  import clpc_pkg::*;

  // One result bit per stage, most significant first. Each stage keeps the
  // remainder num - k*k*den and the running product k*den, so a trial needs
  // only shifts, one add and one compare.
  logic          v_r   [KW];
  logic [NW-1:0] rem_r [KW];
  logic [NW-1:0] kd_r  [KW];
  logic [NW-1:0] den_r [KW];
  logic [KW-1:0] k_r   [KW];

  for (genvar j = 0; j < KW; j++) begin : g_step
    localparam int B = KW - 1 - j;
    logic          v_in;
    logic [NW-1:0] rem_in, kd_in, den_in, trial;
    logic [KW-1:0] k_in;
    logic          take;

    if (j == 0) begin : g_first
      assign v_in   = req.valid;
      assign rem_in = req.num;
      assign kd_in  = '0;
      assign den_in = req.den;
      assign k_in   = '0;
    end else begin : g_next
      assign v_in   = v_r[j-1];
      assign rem_in = rem_r[j-1];
      assign kd_in  = kd_r[j-1];
      assign den_in = den_r[j-1];
      assign k_in   = k_r[j-1];
    end

    assign trial = (kd_in << (B + 1)) + (den_in << (2 * B));
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[j] <= den_in;
        if (take) begin
          rem_r[j] <= rem_in - trial;
          kd_r[j]  <= kd_in + (den_in << B);
          k_r[j]   <= k_in | (KW'(1) << B);
        end else begin
          rem_r[j] <= rem_in;
          kd_r[j]  <= kd_in;
          k_r[j]   <= k_in;
        end
      end
    end
  end

  assign dist_valid = v_r[KW-1];
  assign dist_k     = k_r[KW-1];

endmodule

// ----- rtl/capsule_line_pixel_coverage.sv -----
// Antialiased capsule line coverage. Each transfer on the in_ channel carries
// one pixel; its centre's distance to the configured segment gives the
// coverage in 1/256 units and the line alpha scaled by it. One pixel is taken
// every clock while in_stall is low. Its result reaches the output through
// all stages in order: the transfer itself loads the first of five geometry
// stages (offsets, products, sums, cross product square, operand assembly),
// then come fifteen square root stages that each settle one bit of the
// distance, and one output stage. in_stall follows out_stall only while a
// result sits unread in the output register. Configuration writes are always
// taken (cfg_ready is high) and must be made while no pixel is in flight.
`include "assert_macros.svh"

module capsule_line_pixel_coverage (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [clpc_pkg::PIXEL_COORD_BITS-1:0]  in_pixel_x,
  input  logic [clpc_pkg::PIXEL_COORD_BITS-1:0]  in_pixel_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_covered,
  output logic [8:0]                             out_coverage,
  output logic [7:0]                             out_pixel_alpha,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [clpc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [clpc_pkg::CW_COORD-1:0]          cfg_data
);
  import clpc_pkg::*;

  // Configuration registers.
  logic [CW_COORD-1:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic [CW_THICK-1:0] thick_r;
  logic [CW_ALPHA-1:0] alpha_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      end_x_r   <= '0;
      end_y_r   <= '0;
      thick_r   <= CW_THICK'(16);
      alpha_r   <= CW_ALPHA'(255);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_X: start_x_r <= cfg_data;
        CFG_START_Y: start_y_r <= cfg_data;
        CFG_END_X:   end_x_r   <= cfg_data;
        CFG_END_Y:   end_y_r   <= cfg_data;
        CFG_THICK:   thick_r   <= cfg_data[CW_THICK-1:0];
        CFG_ALPHA:   alpha_r   <= cfg_data[CW_ALPHA-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together unless a result waits at the output.
  logic out_valid_r;
  logic adv;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  seg_t      seg;
  root_req_t req;
  logic      dist_valid;
  logic [KW-1:0] dist_k;

  assign seg.ax = start_x_r;
  assign seg.ay = start_y_r;
  assign seg.bx = end_x_r;
  assign seg.by = end_y_r;

  clpc_geom u_geom (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .load  (in_valid),
    .px    (in_pixel_x),
    .py    (in_pixel_y),
    .seg   (seg),
    .req   (req)
  );

  clpc_root u_root (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .req        (req),
    .dist_valid (dist_valid),
    .dist_k     (dist_k)
  );

  // Output: coverage = clamp(4*thickness + 128 - distance, 0, 256), 0 if off.
  logic               covered_r;
  logic [8:0]         coverage_r;
  logic [7:0]         pixel_alpha_r;
  logic signed [17:0] cov_raw;
  logic [8:0]         cov_sat;
  logic [15:0]        alpha_prod;
  logic               off;

  always_comb begin
    cov_raw = $signed({4'b0, thick_r, 2'b00}) + 18'sd128 - $signed({3'b0, dist_k});
    if (cov_raw < 0) begin
      cov_sat = '0;
    end else if (cov_raw > 18'sd256) begin
      cov_sat = 9'd256;
    end else begin
      cov_sat = cov_raw[8:0];
    end
    off        = (alpha_r == '0) || (thick_r == '0);
    alpha_prod = alpha_r * cov_sat + 16'd128;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dist_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      covered_r     <= !off && (cov_sat != '0);
      coverage_r    <= off ? 9'd0 : cov_sat;
      pixel_alpha_r <= off ? 8'd0 : alpha_prod[15:8];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_covered     = covered_r;
  assign out_coverage    = coverage_r;
  assign out_pixel_alpha = pixel_alpha_r;

  `CLPC_ASSERT_IMP(a_cov_range, out_valid_r, coverage_r <= 9'd256)
  `CLPC_ASSERT_IMP(a_covered_flag, out_valid_r, covered_r == (coverage_r != 9'd0))
  `CLPC_ASSERT_IMP(a_alpha_zero, out_valid_r && (coverage_r == 9'd0), pixel_alpha_r == 8'd0)

endmodule
